/* rtl/slid_pkg.sv */
// Shared types and constants for the sorted list insert/delete block.
package slid_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam int ValueW = 32;
  localparam int CountW = 5;
  localparam int QDepth = 2;
  localparam int QAddrW = 1;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } cmd_t;

endpackage

/* rtl/slid_front.sv */
// Front end: accepts input items, drops unused opcodes, queues commands.
module slid_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic signed [31:0]          value_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output slid_pkg::cmd_t              q_cmd_o
);
  import slid_pkg::*;

  logic op_known;

  always_comb begin
    op_known = opcode_i inside {OP_INSERT, OP_DELETE, OP_DUMP};
  end

  assign in_stall_o    = q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i && op_known;
  assign q_cmd_o.op    = op_e'(opcode_i);
  assign q_cmd_o.value = value_i;

endmodule

/* rtl/slid_fifo.sv */
// Short command queue between the front end and the table engine.
module slid_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slid_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output slid_pkg::cmd_t data_o,
  output logic           empty_o
);
  import slid_pkg::*;

  cmd_t                store_q [QDepth];
  logic [QAddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAddrW:0]     fill_q, fill_d;

  assign full_o  = (fill_q == (QAddrW+1)'(QDepth));
  assign empty_o = (fill_q == '0);
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/slid_back.sv */
// Table engine: sorted entry memory, insert/delete/dump sequencer, output register.
module slid_back #(
  parameter int DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  slid_pkg::cmd_t        q_cmd_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    entry_value_o,
  output logic [1:0]            status_o,
  output logic [4:0]            entry_count_o,
  output logic                  last_o
);
  import slid_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_WRV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic signed [ValueW-1:0] mem [DEPTH];
  logic signed [ValueW-1:0] rd_data_q;

  logic [2:0]               state_q, state_d;
  op_e                      op_q, op_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     found_q, found_d;
  status_e                  st_q, st_d;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_entry_q;
  status_e                  out_status_q;
  logic [CountW-1:0]        out_count_q;
  logic                     out_last_q;

  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [ValueW-1:0] wd;
  logic                     load;
  logic signed [ValueW-1:0] ld_entry;
  status_e                  ld_status;
  logic                     ld_last;
  logic                     out_free;
  logic [CW-1:0]            cnt_last;
  logic                     at_last;
  logic [CW+CountW-1:0]     cnt_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = cnt_q - 1'b1;
  assign at_last  = (CW'(idx_q) == cnt_last);
  assign cnt_ext  = (CW+CountW)'(cnt_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    st_d      = st_q;
    we        = 1'b0;
    wa        = '0;
    wd        = val_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    ld_entry  = '0;
    ld_status = st_q;
    ld_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          op_d    = q_cmd_i.op;
          val_d   = q_cmd_i.value;
          idx_d   = '0;
          found_d = 1'b0;
          case (q_cmd_i.op)
            OP_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                st_d    = ST_FULL;
                state_d = S_OUT;
              end else if (cnt_q == '0) begin
                state_d = S_WRV;
              end else begin
                idx_d   = AW'(cnt_last);
                state_d = S_RD;
              end
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                st_d    = ST_NOTFOUND;
                state_d = S_OUT;
              end else begin
                state_d = S_RD;
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_OUT;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_ACT;
      end
      S_ACT: begin
        case (op_q)
          OP_INSERT: begin
            we = 1'b1;
            wa = idx_q + 1'b1;
            if (rd_data_q >= val_q) begin
              wd = rd_data_q;
              if (idx_q == '0) begin
                state_d = S_WRV;
              end else begin
                idx_d   = idx_q - 1'b1;
                state_d = S_RD;
              end
            end else begin
              wd      = val_q;
              cnt_d   = cnt_q + 1'b1;
              st_d    = ST_OK;
              state_d = S_OUT;
            end
          end
          OP_DELETE: begin
            if (found_q) begin
              we = 1'b1;
              wa = idx_q - 1'b1;
              wd = rd_data_q;
            end
            found_d = found_q || (rd_data_q == val_q);
            if (at_last) begin
              if (found_d) begin
                cnt_d = cnt_q - 1'b1;
                st_d  = ST_OK;
              end else begin
                st_d  = ST_NOTFOUND;
              end
              state_d = S_OUT;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          OP_DUMP: begin
            if (out_free) begin
              load      = 1'b1;
              ld_entry  = rd_data_q;
              ld_status = ST_OK;
              ld_last   = at_last;
              if (at_last) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = S_RD;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_WRV: begin
        we      = 1'b1;
        wa      = '0;
        wd      = val_q;
        cnt_d   = cnt_q + 1'b1;
        st_d    = ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load      = 1'b1;
          ld_entry  = '0;
          ld_status = st_q;
          ld_last   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INSERT;
      idx_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      st_q    <= st_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (load) begin
      out_entry_q  <= ld_entry;
      out_status_q <= ld_status;
      out_count_q  <= cnt_ext[CountW-1:0];
      out_last_q   <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_entry_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

endmodule

/* rtl/sorted_list_insert_delete.sv */
// Sorted list of signed 32-bit keys with insert, delete and in-order dump.
// Items pass through a two-entry command queue into a table engine that keeps up
// to DEPTH keys in ascending order in a memory with one write port and a registered
// read port, so the engine reads one entry, then acts on it, before it moves on. An
// insert scans down from the last entry and shifts each entry not below the key up
// by one before it writes the key, a delete scans every entry and shifts those after
// the match down, and a dump sends each entry in order, held by output stalls. A full
// table on insert, or an empty one on delete or dump, skips the scan. Opcode 3 is
// taken and dropped with no result. The final result of each item carries last.
module sorted_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] entry_value_o,
  output logic [1:0]         status_o,
  output logic [4:0]         entry_count_o,
  output logic               last_o
);
  import slid_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  slid_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  slid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd_out),
    .empty_o (q_empty)
  );

  slid_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_cmd_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_value_o (entry_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule
